[hdl/led_blink_code_sequencer_core_assert.svh]
// Assertion macros shared by the blink code sequencer modules
`ifndef LED_BLINK_CODE_SEQUENCER_CORE_ASSERT_SVH
`define LED_BLINK_CODE_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define LBCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define LBCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/lbcs_pkg.sv]
// Package: types, codes and constants of the blink code sequencer
`timescale 1ns / 1ps
`default_nettype none

package lbcs_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF = 8;
    localparam int CODE_W         = 8;
    localparam int TICKS_W        = 16;
    localparam int REPEAT_W       = 8;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 2;
    localparam int PHASE_W        = 3;

    typedef enum logic [PHASE_W-1:0] {
        PH_START = 3'd0,
        PH_ON    = 3'd1,
        PH_OFF   = 3'd2,
        PH_PAUSE = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_ON_TICKS     = 2'd0,
        CFG_OFF_TICKS    = 2'd1,
        CFG_PAUSE_TICKS  = 2'd2,
        CFG_REPEAT_COUNT = 2'd3
    } cfg_idx_t;

    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_LOAD = 1'b1
    } func_t;

    typedef struct packed {
        logic              func;
        logic [CODE_W-1:0] code;
    } lbcs_in_t;

    typedef struct packed {
        logic led_on;
        logic busy_res;
    } lbcs_out_t;

    typedef struct packed {
        logic [TICKS_W-1:0]  on_ticks;
        logic [TICKS_W-1:0]  off_ticks;
        logic [TICKS_W-1:0]  pause_ticks;
        logic [REPEAT_W-1:0] repeat_count;
    } lbcs_cfg_t;

endpackage

`default_nettype wire

[hdl/lbcs_cfg.sv]
// Configuration register file of the blink code sequencer
`timescale 1ns / 1ps
`default_nettype none

module lbcs_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [lbcs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lbcs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output      lbcs_pkg::lbcs_cfg_t              cfg
);
    import lbcs_pkg::*;

    lbcs_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_ticks     <= TICKS_W'(10);
            cfg_reg.off_ticks    <= TICKS_W'(20);
            cfg_reg.pause_ticks  <= TICKS_W'(60);
            cfg_reg.repeat_count <= REPEAT_W'(0);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ON_TICKS:     cfg_reg.on_ticks     <= cfg_data[TICKS_W-1:0];
                CFG_OFF_TICKS:    cfg_reg.off_ticks    <= cfg_data[TICKS_W-1:0];
                CFG_PAUSE_TICKS:  cfg_reg.pause_ticks  <= cfg_data[TICKS_W-1:0];
                CFG_REPEAT_COUNT: cfg_reg.repeat_count <= cfg_data[REPEAT_W-1:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[hdl/lbcs_step.sv]
// Phase sequencer: state registers and per-word next-state logic
`timescale 1ns / 1ps
`default_nettype none

module lbcs_step #(
    parameter int TIMER_BITS = lbcs_pkg::TIMER_BITS_DEF,
    parameter int COUNT_BITS = lbcs_pkg::COUNT_BITS_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                fire,
    input  wire lbcs_pkg::lbcs_in_t  word,
    input  wire lbcs_pkg::lbcs_cfg_t cfg,
    output      lbcs_pkg::lbcs_out_t result
);
    import lbcs_pkg::*;

    `include "led_blink_code_sequencer_core_assert.svh"

    localparam int TW    = (TIMER_BITS > TICKS_W) ? TIMER_BITS : TICKS_W;
    localparam int CMP_W = (COUNT_BITS > CODE_W) ? COUNT_BITS : CODE_W;
    localparam int RPT_W = (COUNT_BITS > REPEAT_W) ? COUNT_BITS : REPEAT_W;

    phase_t                phase_reg,   phase_next;
    logic [TIMER_BITS-1:0] timer_reg,   timer_next;
    logic [COUNT_BITS-1:0] blinks_reg,  blinks_next;
    logic [COUNT_BITS-1:0] repeats_reg, repeats_next;
    logic [CODE_W-1:0]     code_reg,    code_next;
    logic                  led_reg,     led_next;
    logic                  busy_reg,    busy_next;

    logic [TW-1:0]         on_wide, off_wide, pause_wide;
    logic [TIMER_BITS-1:0] on_load, off_load, pause_load;
    logic                  timer_zero;
    logic [TIMER_BITS-1:0] timer_dec;
    logic [COUNT_BITS-1:0] blinks_inc, repeats_inc;
    logic                  more_blinks, more_repeats, endless;

    assign on_wide    = TW'(cfg.on_ticks);
    assign off_wide   = TW'(cfg.off_ticks);
    assign pause_wide = TW'(cfg.pause_ticks);
    assign on_load    = on_wide[TIMER_BITS-1:0];
    assign off_load   = off_wide[TIMER_BITS-1:0];
    assign pause_load = pause_wide[TIMER_BITS-1:0];

    assign timer_zero   = (timer_reg == '0);
    assign timer_dec    = timer_reg - 1'b1;
    assign blinks_inc   = blinks_reg + 1'b1;
    assign repeats_inc  = repeats_reg + 1'b1;
    assign more_blinks  = (CMP_W'(blinks_inc) < CMP_W'(code_reg));
    assign more_repeats = (RPT_W'(repeats_inc) < RPT_W'(cfg.repeat_count));
    assign endless      = (cfg.repeat_count == '0);

    always_comb
    begin
        phase_next = phase_reg;
        if (fire)
        begin
            if (word.func == FUNC_LOAD)
            begin
                phase_next = PH_START;
            end
            else
            begin
                unique case (phase_reg)
                    PH_START: phase_next = (code_reg == '0) ? PH_DONE : PH_ON;
                    PH_ON:    phase_next = timer_zero ? PH_OFF : PH_ON;
                    PH_OFF:
                    begin
                        if (timer_zero)
                        begin
                            phase_next = more_blinks ? PH_ON : PH_PAUSE;
                        end
                    end
                    PH_PAUSE:
                    begin
                        if (timer_zero)
                        begin
                            phase_next = (endless || more_repeats) ? PH_START : PH_DONE;
                        end
                    end
                    default:  phase_next = phase_reg;
                endcase
            end
        end
    end

    always_comb
    begin
        timer_next   = timer_reg;
        blinks_next  = blinks_reg;
        repeats_next = repeats_reg;
        code_next    = code_reg;
        led_next     = led_reg;
        busy_next    = busy_reg;
        if (fire)
        begin
            if (word.func == FUNC_LOAD)
            begin
                code_next    = word.code;
                repeats_next = '0;
                busy_next    = 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_START:
                    begin
                        timer_next  = on_load;
                        blinks_next = '0;
                        if (code_reg == '0)
                        begin
                            led_next = 1'b0;
                        end
                    end
                    PH_ON:
                    begin
                        led_next   = 1'b1;
                        timer_next = timer_zero ? off_load : timer_dec;
                    end
                    PH_OFF:
                    begin
                        led_next = 1'b0;
                        if (timer_zero)
                        begin
                            blinks_next = blinks_inc;
                            timer_next  = more_blinks ? on_load : pause_load;
                        end
                        else
                        begin
                            timer_next = timer_dec;
                        end
                    end
                    PH_PAUSE:
                    begin
                        led_next = 1'b0;
                        if (timer_zero)
                        begin
                            repeats_next = repeats_inc;
                            if (endless)
                            begin
                                busy_next = 1'b0;
                            end
                        end
                        else
                        begin
                            timer_next = timer_dec;
                        end
                    end
                    default: busy_next = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_DONE;
            timer_reg   <= '0;
            blinks_reg  <= '0;
            repeats_reg <= '0;
            code_reg    <= '0;
            led_reg     <= 1'b0;
            busy_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            blinks_reg  <= blinks_next;
            repeats_reg <= repeats_next;
            code_reg    <= code_next;
            led_reg     <= led_next;
            busy_reg    <= busy_next;
        end
    end

    assign result.led_on   = led_next;
    assign result.busy_res = busy_next;

    `LBCS_ASSERT_NEXT(a_load_starts, fire && (word.func == FUNC_LOAD),
        (phase_reg == PH_START) && busy_reg, "load did not restart the sequence")
    `LBCS_ASSERT_NOW(a_pause_dark, phase_reg == PH_PAUSE, !led_reg,
        "LED lit during pause")
    `LBCS_ASSERT_NEXT(a_done_clears_busy,
        fire && (word.func == FUNC_TICK) && (phase_reg == PH_DONE), !busy_reg,
        "busy still set after tick in done")

endmodule

`default_nettype wire

[hdl/lbcs_out.sv]
// Result register with skid stage
`timescale 1ns / 1ps
`default_nettype none

module lbcs_out (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output      logic                in_ready,
    input  wire lbcs_pkg::lbcs_out_t result,
    output      logic                out_valid,
    input  wire logic                out_ready,
    output      lbcs_pkg::lbcs_out_t out_data
);
    import lbcs_pkg::*;

    `include "led_blink_code_sequencer_core_assert.svh"

    lbcs_out_t data_reg;
    lbcs_out_t skid_reg;
    logic      out_valid_reg;
    logic      skid_valid_reg;
    logic      in_fire;
    logic      out_fire;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || out_ready)
        begin
            data_reg <= skid_valid_reg ? skid_reg : result;
        end
        else if (in_fire)
        begin
            skid_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = data_reg;

    `LBCS_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid word held without an output word")
    `LBCS_ASSERT_NEXT(a_stall_to_skid, in_fire && out_valid_reg && !out_ready,
        skid_valid_reg, "stalled word not parked in skid")
    `LBCS_ASSERT_NEXT(a_drain_empties, out_fire && !skid_valid_reg && !in_fire,
        !out_valid_reg, "output still valid after drain")

endmodule

`default_nettype wire

[hdl/led_blink_code_sequencer_core.sv]
// Top level of the LED blink code sequencer
//
// Input channel (in_valid / in_ready / in_data): each word is a tick
// (func = 0) or a load of a new code (func = 1, code = blink count).
// Output channel (out_valid / out_ready / out_data): one word per input
// word, carrying the LED level and busy flag after that input.
// Config port (cfg_we / cfg_index / cfg_data): single-cycle writes of
// on_ticks, off_ticks, pause_ticks and repeat_count; no read-back.
// The result reaches out_data through the result register, by way of the skid stage when the output stalls.
// Throughput: one word per cycle while in_ready is high; each word's phase
// update between the sequencer state registers is combinational.
// Stall: a result register plus a one-word skid stage; in_ready drops
// only when both hold words the receiver has not taken.
// Reset: phase done, LED off, busy clear, counters zero, registers at
// 10 / 20 / 60 / 0; both channels empty.
`timescale 1ns / 1ps
`default_nettype none

module led_blink_code_sequencer_core #(
    parameter int TIMER_BITS = lbcs_pkg::TIMER_BITS_DEF,
    parameter int COUNT_BITS = lbcs_pkg::COUNT_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output      logic                             in_ready,
    input  wire lbcs_pkg::lbcs_in_t               in_data,
    output      logic                             out_valid,
    input  wire logic                             out_ready,
    output      lbcs_pkg::lbcs_out_t              out_data,
    input  wire logic                             cfg_we,
    input  wire logic [lbcs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [lbcs_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lbcs_pkg::*;

    lbcs_cfg_t cfg;
    lbcs_out_t result;
    logic      in_fire;

    assign in_fire = in_valid && in_ready;

    lbcs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lbcs_step #(
        .TIMER_BITS (TIMER_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_step (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (in_fire),
        .word   (in_data),
        .cfg    (cfg),
        .result (result)
    );

    lbcs_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .result    (result),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
